// File: hw/rtl/srf_pkg.sv
// ----------------------------------------------------------------------------
// Spike removal filter package
// Shared widths, register indexes, command and status types and a helper.
// ----------------------------------------------------------------------------
package srf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TOL_W      = 16;
    localparam int LEN_W      = 4;
    localparam int SEEN_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLAT_TOL   = 3'd0,
        REG_JUMP_TOL   = 3'd1,
        REG_BEFORE_LEN = 3'd2,
        REG_AFTER_LEN  = 3'd3,
        REG_SPIKE_LEN  = 3'd4,
        REG_USE_LEFT   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [TOL_W-1:0] flat_tol;
        logic [TOL_W-1:0] jump_tol;
        logic [LEN_W-1:0] before_len;
        logic [LEN_W-1:0] after_len;
        logic [LEN_W-1:0] spike_len;
        logic             use_left;
    } t_cfg;

    // Kind of original-window read issued in a cycle.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LEFT  = 3'd1,
        OP_RIGHT = 3'd2,
        OP_FLATL = 3'd3,
        OP_FLATR = 3'd4,
        OP_JUMP  = 3'd5
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic cnt_clr;
        logic cnt_step;
        logic fix_wr;
        logic emit_rd;
        logic out_load;
        logic seq_end;
    } t_cmd;

    typedef struct packed {
        logic test_en;
        logic spike_zero;
        logic spike_last;
        logic flatl_zero;
        logic flatl_last;
        logic flatr_zero;
        logic flatr_last;
        logic ok;
        logic emit_more;
        logic eos;
        logic out_free;
    } t_stat;

    // Magnitude of the difference of two signed samples; it always fits 16 bits.
    function automatic logic [TOL_W-1:0] absdiff(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic signed [SAMPLE_W-1:0] y);
        logic signed [SAMPLE_W:0] d;
        logic signed [SAMPLE_W:0] m;
        d = {x[SAMPLE_W-1], x} - {y[SAMPLE_W-1], y};
        m = d[SAMPLE_W] ? -d : d;
        return m[TOL_W-1:0];
    endfunction

endpackage

// File: hw/rtl/srf_in_if.sv
// ----------------------------------------------------------------------------
// Spike removal filter input channel
// Valid/ready channel carrying one raw sample and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface srf_in_if import srf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       end_of_stream;

    modport source (output valid, output sample_in, output end_of_stream, input ready);
    modport sink   (input valid, input sample_in, input end_of_stream, output ready);

endinterface

// File: hw/rtl/srf_out_if.sv
// ----------------------------------------------------------------------------
// Spike removal filter output channel
// Valid/ready channel carrying one filtered sample and its last flag.
// ----------------------------------------------------------------------------
interface srf_out_if import srf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);

endinterface

// File: hw/rtl/srf_ctrl.sv
// ----------------------------------------------------------------------------
// Spike removal filter controller
// Sequences the window reads, the spike tests, the repair and the emission.
// ----------------------------------------------------------------------------
module srf_ctrl import srf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LEFT,
        S_RIGHT,
        S_FLATL,
        S_FLATR,
        S_JUMP,
        S_DRAIN,
        S_FIX,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept  = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (i_stat.test_en && !i_stat.spike_zero) ? S_LEFT : S_EMIT_RD;
            end
            S_LEFT: begin
                o_cmd.op = OP_LEFT;
                n_state  = S_RIGHT;
            end
            S_RIGHT: begin
                o_cmd.op = OP_RIGHT;
                if (!i_stat.flatl_zero) begin
                    n_state = S_FLATL;
                end else if (!i_stat.flatr_zero) begin
                    n_state = S_FLATR;
                end else begin
                    n_state = S_JUMP;
                end
            end
            S_FLATL: begin
                o_cmd.op = OP_FLATL;
                if (i_stat.flatl_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = i_stat.flatr_zero ? S_JUMP : S_FLATR;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            S_FLATR: begin
                o_cmd.op = OP_FLATR;
                if (i_stat.flatr_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_JUMP;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            S_JUMP: begin
                o_cmd.op = OP_JUMP;
                if (i_stat.spike_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_DRAIN;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                if (!i_stat.ok) begin
                    n_state = S_EMIT_RD;
                end else begin
                    o_cmd.fix_wr = 1'b1;
                    if (i_stat.spike_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_EMIT_RD;
                    end else begin
                        o_cmd.cnt_step = 1'b1;
                    end
                end
            end
            S_EMIT_RD: begin
                if (i_stat.emit_more) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_EMIT_LD;
                end else begin
                    o_cmd.seq_end = i_stat.eos;
                    n_state       = S_IDLE;
                end
            end
            S_EMIT_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/srf_dp.sv
// ----------------------------------------------------------------------------
// Spike removal filter datapath
// Sample windows, read pipeline, comparator, repair writes and output register.
// ----------------------------------------------------------------------------
module srf_dp import srf_pkg::*; #(
    parameter int MAX_BEFORE   = 8,
    parameter int MAX_AFTER    = 8,
    parameter int MAX_SPIKE    = 8,
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_eos,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic                       o_out_last
);

    localparam int SUM_MAX  = MAX_SPIKE + MAX_AFTER + MAX_BEFORE;
    localparam int BACK_MAX = (SUM_MAX > WINDOW_DEPTH) ? SUM_MAX : WINDOW_DEPTH;
    localparam int BACK_W   = $clog2(BACK_MAX + 1);
    localparam int NWRAP    = BACK_MAX / WINDOW_DEPTH;
    localparam int HEAD_W   = $clog2(WINDOW_DEPTH);
    localparam int P_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int JMAX_BA  = (MAX_BEFORE > MAX_AFTER) ? MAX_BEFORE : MAX_AFTER;
    localparam int JMAX     = (JMAX_BA > MAX_SPIKE) ? JMAX_BA : MAX_SPIKE;
    localparam int J_W      = $clog2(JMAX + 1);
    localparam int CW       = ((BACK_W > SEEN_W) ? BACK_W : SEEN_W) + 1;

    // Slot of the sample lying 'back' places before the newest one.
    function automatic logic [HEAD_W-1:0] slot_of(input logic [BACK_W-1:0] back,
                                                   input logic [HEAD_W-1:0] head);
        logic [BACK_W-1:0] r;
        logic [HEAD_W:0]   t;
        r = back;
        for (int k = 0; k < NWRAP; k++) begin
            if (r >= BACK_W'(WINDOW_DEPTH)) begin
                r = r - BACK_W'(WINDOW_DEPTH);
            end
        end
        t = {1'b0, head} - (HEAD_W + 1)'(r);
        if ({1'b0, head} < (HEAD_W + 1)'(r)) begin
            t = t + (HEAD_W + 1)'(WINDOW_DEPTH);
        end
        return t[HEAD_W-1:0];
    endfunction

    logic signed [SAMPLE_W-1:0] r_orig_mem [WINDOW_DEPTH];
    logic signed [SAMPLE_W-1:0] r_filt_mem [WINDOW_DEPTH];
    logic signed [SAMPLE_W-1:0] r_orig_rd;
    logic signed [SAMPLE_W-1:0] r_filt_rd;
    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_right;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [HEAD_W-1:0]          r_head;
    logic [SEEN_W-1:0]          r_seen;
    logic [P_W-1:0]             r_pending;
    logic [J_W-1:0]             r_j;
    t_op                        r_op_q;
    logic                       r_ok;
    logic                       n_ok;
    logic                       r_eos;
    logic                       r_rd_last;
    logic                       r_out_valid;
    logic                       r_out_last;

    logic [4:0]                 w_b5;
    logic [4:0]                 w_a5;
    logic [4:0]                 w_s5;
    logic [BACK_W-1:0]          w_b;
    logic [BACK_W-1:0]          w_a;
    logic [BACK_W-1:0]          w_s;
    logic [BACK_W-1:0]          w_d;
    logic [BACK_W-1:0]          w_j;
    logic [BACK_W-1:0]          w_back;
    logic [HEAD_W-1:0]          w_addr;
    logic [HEAD_W-1:0]          w_head_inc;
    logic signed [SAMPLE_W-1:0] w_fix_val;

    // Clamp the lengths to their legal ranges.
    always_comb begin
        w_b5 = {1'b0, i_cfg.before_len};
        if (w_b5 == 5'd0) begin
            w_b5 = 5'd1;
        end else if (w_b5 > 5'(MAX_BEFORE)) begin
            w_b5 = 5'(MAX_BEFORE);
        end
        w_a5 = {1'b0, i_cfg.after_len};
        if (w_a5 > 5'(MAX_AFTER)) begin
            w_a5 = 5'(MAX_AFTER);
        end
        w_s5 = {1'b0, i_cfg.spike_len};
        if (w_s5 > 5'(MAX_SPIKE)) begin
            w_s5 = 5'(MAX_SPIKE);
        end
    end

    assign w_b = BACK_W'(w_b5);
    assign w_a = BACK_W'(w_a5);
    assign w_s = BACK_W'(w_s5);
    assign w_d = w_s + w_a;
    assign w_j = BACK_W'(r_j);

    assign w_head_inc = (r_head == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_fix_val  = i_cfg.use_left ? r_left : r_right;

    always_comb begin
        if (i_cmd.emit_rd) begin
            w_back = BACK_W'(r_pending) - BACK_W'(1);
        end else if (i_cmd.fix_wr) begin
            w_back = w_d - w_j;
        end else begin
            case (i_cmd.op)
                OP_LEFT:  w_back = w_d + BACK_W'(1);
                OP_RIGHT: w_back = w_a;
                OP_FLATL: w_back = w_d + BACK_W'(2) + w_j;
                OP_FLATR: w_back = w_a - w_j;
                OP_JUMP:  w_back = w_d - w_j;
                default:  w_back = '0;
            endcase
        end
    end

    assign w_addr = slot_of(w_back, r_head);

    // Windows: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_orig_mem[w_head_inc] <= i_sample;
        end
        r_orig_rd <= r_orig_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_filt_mem[w_head_inc] <= i_sample;
        end else if (i_cmd.fix_wr) begin
            r_filt_mem[w_addr] <= w_fix_val;
        end
        if (i_cmd.emit_rd) begin
            r_filt_rd <= r_filt_mem[w_addr];
        end
    end

    // Comparator stage on the data read in the previous cycle.
    always_comb begin
        n_ok = r_ok;
        if (i_cmd.op == OP_LEFT) begin
            n_ok = 1'b1;
        end
        case (r_op_q)
            OP_FLATL: begin
                if (absdiff(r_left, r_orig_rd) > i_cfg.flat_tol) begin
                    n_ok = 1'b0;
                end
            end
            OP_FLATR: begin
                if (absdiff(r_right, r_orig_rd) > i_cfg.flat_tol) begin
                    n_ok = 1'b0;
                end
            end
            OP_JUMP: begin
                if (absdiff(r_left, r_orig_rd) <= i_cfg.jump_tol ||
                    absdiff(r_right, r_orig_rd) <= i_cfg.jump_tol) begin
                    n_ok = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_op_q == OP_LEFT) begin
            r_left <= r_orig_rd;
        end
        if (r_op_q == OP_RIGHT) begin
            r_right <= r_orig_rd;
        end
        if (i_cmd.emit_rd) begin
            r_rd_last <= r_eos && (r_pending == P_W'(1));
        end
        if (i_cmd.out_load) begin
            r_out_sample <= r_filt_rd;
            r_out_last   <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_seen      <= '0;
            r_pending   <= '0;
            r_j         <= '0;
            r_op_q      <= OP_NONE;
            r_ok        <= 1'b0;
            r_eos       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_op_q <= i_cmd.op;
            r_ok   <= n_ok;
            if (i_cmd.accept) begin
                r_head <= w_head_inc;
                r_eos  <= i_eos;
                if (r_seen != SEEN_MAX) begin
                    r_seen <= r_seen + 1'b1;
                end
                if (r_pending != P_W'(WINDOW_DEPTH)) begin
                    r_pending <= r_pending + 1'b1;
                end
            end else if (i_cmd.emit_rd) begin
                r_pending <= r_pending - 1'b1;
            end else if (i_cmd.seq_end) begin
                r_seen    <= '0;
                r_pending <= '0;
            end
            if (i_cmd.cnt_clr) begin
                r_j <= '0;
            end else if (i_cmd.cnt_step) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.test_en    = CW'(r_seen) >= (CW'(w_d) + CW'(w_b) + CW'(1));
        o_stat.spike_zero = (w_s == '0);
        o_stat.spike_last = ((w_j + BACK_W'(1)) == w_s);
        o_stat.flatl_zero = (w_b == BACK_W'(1));
        o_stat.flatl_last = ((w_j + BACK_W'(2)) == w_b);
        o_stat.flatr_zero = (w_a == '0);
        o_stat.flatr_last = ((w_j + BACK_W'(1)) == w_a);
        o_stat.ok         = r_ok;
        o_stat.emit_more  = (r_pending != '0) && (r_eos || (BACK_W'(r_pending) > w_d));
        o_stat.eos        = r_eos;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_last   = r_out_last;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_rd |-> (r_pending != '0))
        else $error("emission read with no held sample");

    a_fix_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fix_wr |-> (r_ok && (w_s != '0)))
        else $error("repair write without a passed spike test");

    a_seq_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seq_end |=> ((r_seen == '0) && (r_pending == '0)))
        else $error("sequence counters not cleared after the final sample");
`endif

endmodule

// File: hw/rtl/spike_removal_filter.sv
// ----------------------------------------------------------------------------
// Spike removal filter
// Operation: a request is accepted in the idle state. When a position is tested,
//   the neighbour reads, flatness checks, jump checks and any repair come before
//   its first result; if the window is too short for a test, emission follows.
// Requests do not overlap: the next is accepted only once all results are loaded,
//   and the single comparator walks the window one sample per cycle.
// Reset: synchronous, active low; sample windows and data registers are not reset.
// ----------------------------------------------------------------------------
module spike_removal_filter import srf_pkg::*; #(
    parameter int MAX_BEFORE   = 8,
    parameter int MAX_AFTER    = 8,
    parameter int MAX_SPIKE    = 8,
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    srf_in_if.sink                i_in,
    srf_out_if.source             o_out
);

    // Configuration registers. The user must make writes only while the filter is idle;
    // the block does not enforce it, and the datapath uses these values directly.
    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flat_tol   <= '0;
            r_cfg.jump_tol   <= '0;
            r_cfg.before_len <= LEN_W'(2);
            r_cfg.after_len  <= LEN_W'(2);
            r_cfg.spike_len  <= LEN_W'(1);
            r_cfg.use_left   <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FLAT_TOL:   r_cfg.flat_tol   <= i_cfg_data[TOL_W-1:0];
                REG_JUMP_TOL:   r_cfg.jump_tol   <= i_cfg_data[TOL_W-1:0];
                REG_BEFORE_LEN: r_cfg.before_len <= i_cfg_data[LEN_W-1:0];
                REG_AFTER_LEN:  r_cfg.after_len  <= i_cfg_data[LEN_W-1:0];
                REG_SPIKE_LEN:  r_cfg.spike_len  <= i_cfg_data[LEN_W-1:0];
                REG_USE_LEFT:   r_cfg.use_left   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The controller walks each tested request through its phases: the two
    // neighbour reads, the flatness checks on either side, the jump checks
    // over the spike run, the repair writes and finally the emission of every
    // sample that has become final. It only accepts a new request once all
    // results of the previous one have been handed to the output register.
    srf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds both sample windows as memories. The original window
    // feeds the comparator; the filtered window collects repairs and is read
    // out in input order. A result register decouples the output channel, so
    // the last result of a request may wait there while the next is accepted.
    srf_dp #(
        .MAX_BEFORE   (MAX_BEFORE),
        .MAX_AFTER    (MAX_AFTER),
        .MAX_SPIKE    (MAX_SPIKE),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_sample     (i_in.sample_in),
        .i_eos        (i_in.end_of_stream),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_sample (o_out.sample_out),
        .o_out_last   (o_out.last_out)
    );

    assign i_in.ready = w_in_ready;

endmodule

// File: tb/spike_removal_filter_tb.sv
// ----------------------------------------------------------------------------
// Spike removal filter testbench
// Drives sample requests through the valid/ready input channel. A behavioural
// predictor of the filter tracks every accepted request. Each filtered sample
// leaving the block is compared with the oldest prediction, sample value and
// last flag both. Directed sequences cover the edge cases; random phases then
// cover many register settings, with stalls on both channels.
// ----------------------------------------------------------------------------
module spike_removal_filter_tb;
    import srf_pkg::*;

    localparam int WIN_DEPTH     = 32;
    localparam int MAX_LEN       = 8;
    localparam int SEEN_LIMIT    = 63;
    // Wait after draining before touching the registers, a safe margin over the slowest request.
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 40;
    localparam int TIMEOUT_TU    = 6000000;

    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_filt_sample;

    typedef logic signed [SAMPLE_W-1:0] t_sample_list[$];

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    srf_in_if  in_ch ();
    srf_out_if out_ch ();

    spike_removal_filter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Predictor state. It mirrors the filter: the raw window, the window of
    // filtered values, the count of samples in the current sequence and the
    // count of samples held back. The settings are the values last written.
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] orig_win [WIN_DEPTH];
    logic signed [SAMPLE_W-1:0] filt_win [WIN_DEPTH];
    int unsigned                head_slot = 0;
    int unsigned                seen_cnt  = 0;
    int unsigned                held_cnt  = 0;
    t_cfg                       cfg_m = '{flat_tol: 16'd0, jump_tol: 16'd0, before_len: 4'd2,
                                          after_len: 4'd2, spike_len: 4'd1, use_left: 1'b1};

    t_filt_sample filtered_q[$];

    int unsigned fail_count = 0;
    int unsigned sent_count = 0;
    int unsigned out_count  = 0;
    int unsigned cfg_count  = 0;
    // Idling odds shared by both channels: zero means no idling at all.
    int unsigned idle_odds  = 0;
    int unsigned stall_left = 0;

    function automatic int unsigned clamp_len(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Slot of the sample lying 'back' places behind the newest one.
    function automatic int unsigned back_slot(input int unsigned back);
        return (head_slot + WIN_DEPTH - (back % WIN_DEPTH)) % WIN_DEPTH;
    endfunction

    function automatic int unsigned abs_gap(input logic signed [SAMPLE_W-1:0] x,
                                            input logic signed [SAMPLE_W-1:0] y);
        int diff;
        diff = int'(x) - int'(y);
        return (diff < 0) ? -diff : diff;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_sample(input int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_W'(v);
    endfunction

    // Works out which filtered samples one accepted request releases and
    // queues them in order. The position tested is the one a full delay
    // (spike plus after length) behind the newest sample.
    task automatic predict_filtered(input logic signed [SAMPLE_W-1:0] x, input logic eos);
        int unsigned                b, a, s, d, j;
        logic signed [SAMPLE_W-1:0] left, right, v;
        bit                         ok;
        t_filt_sample               item;
        b = clamp_len(cfg_m.before_len, 1, MAX_LEN);
        a = clamp_len(cfg_m.after_len, 0, MAX_LEN);
        s = clamp_len(cfg_m.spike_len, 0, MAX_LEN);
        d = s + a;
        head_slot = (head_slot + 1) % WIN_DEPTH;
        orig_win[head_slot] = x;
        filt_win[head_slot] = x;
        if (seen_cnt < SEEN_LIMIT) seen_cnt++;
        if (held_cnt < WIN_DEPTH) held_cnt++;
        if (seen_cnt >= d + b + 1) begin
            ok = 1'b1;
            left = orig_win[back_slot(d + 1)];
            right = orig_win[back_slot(a)];
            for (j = 2; j <= b; j++) begin
                if (abs_gap(left, orig_win[back_slot(d + j)]) > cfg_m.flat_tol) ok = 1'b0;
            end
            for (j = 0; j < a; j++) begin
                if (abs_gap(right, orig_win[back_slot(a - j)]) > cfg_m.flat_tol) ok = 1'b0;
            end
            for (j = 0; j < s; j++) begin
                v = orig_win[back_slot(d - j)];
                if (abs_gap(left, v) <= cfg_m.jump_tol || abs_gap(right, v) <= cfg_m.jump_tol)
                    ok = 1'b0;
            end
            if (ok) begin
                for (j = 0; j < s; j++) filt_win[back_slot(d - j)] = cfg_m.use_left ? left : right;
            end
        end
        while (held_cnt > 0 && (eos || held_cnt > d)) begin
            held_cnt--;
            item.sample = filt_win[back_slot(held_cnt)];
            item.last = eos && held_cnt == 0;
            filtered_q.insert(filtered_q.size(), item);
        end
        if (eos) begin
            seen_cnt = 0;
            held_cnt = 0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Checker. Results are checked before the request of the same edge is
    // predicted; a request can never produce a result in the cycle it is
    // accepted, so the order is safe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_proc
        t_filt_sample want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            out_count++;
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d last %0b",
                                          out_ch.sample_out, out_ch.last_out));
            end else begin
                want = filtered_q.pop_front();
                if (out_ch.sample_out !== want.sample)
                    report_mismatch($sformatf("sample %0d, wanted %0d",
                                              out_ch.sample_out, want.sample));
                if (out_ch.last_out !== want.last)
                    report_mismatch($sformatf("last flag %0b, wanted %0b",
                                              out_ch.last_out, want.last));
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready)
            predict_filtered(in_ch.sample_in, in_ch.end_of_stream);
    end

    // The receiver stalls in bursts of random length while idling is on.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds * 2) == 1) begin
            out_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Sends one request and returns at the edge that accepts it. The valid
    // is left high so that a following request goes out without a gap; it
    // is lowered only when a gap or a pause actually comes.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        if (idle_odds != 0 && $urandom_range(1, idle_odds * 2) == 1) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= value;
        in_ch.end_of_stream <= last;
        sent_count++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_list(input t_sample_list vals);
        int unsigned k;
        for (k = 0; k < vals.size(); k++) send_sample(vals[k], k == vals.size() - 1);
    endtask

    // Holds the sender until every predicted sample has come out, then lets
    // the block finish any request that releases nothing. The first edge is
    // awaited before the queue is looked at, so that the prediction of a
    // request accepted at this very edge is already in it.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (filtered_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Writes every register once the block has gone quiet.
    task automatic set_config(input t_cfg c);
        wait_drained();
        write_reg(REG_FLAT_TOL, c.flat_tol);
        write_reg(REG_JUMP_TOL, c.jump_tol);
        write_reg(REG_BEFORE_LEN, CFG_DATA_W'(c.before_len));
        write_reg(REG_AFTER_LEN, CFG_DATA_W'(c.after_len));
        write_reg(REG_SPIKE_LEN, CFG_DATA_W'(c.spike_len));
        write_reg(REG_USE_LEFT, CFG_DATA_W'(c.use_left));
        i_cfg_we <= 1'b0;
        cfg_m = c;
        cfg_count++;
    endtask

    function automatic t_cfg make_cfg(input int unsigned flat, input int unsigned jump,
                                      input int unsigned bef, input int unsigned aft,
                                      input int unsigned spk, input bit left);
        t_cfg c;
        c.flat_tol = TOL_W'(flat);
        c.jump_tol = TOL_W'(jump);
        c.before_len = LEN_W'(bef);
        c.after_len = LEN_W'(aft);
        c.spike_len = LEN_W'(spk);
        c.use_left = left;
        return c;
    endfunction

    // A sequence built of flat stretches that jitter within the flat
    // tolerance, spike runs that clear the jump tolerance, the odd level
    // change and a little pure noise. Most spike runs have exactly the
    // configured length, so that many positions get replaced.
    task automatic send_sequence(input int unsigned len, input bit close);
        int unsigned k, run, s_eff, tol, jmp;
        int          level, v, off;
        bit          up;
        s_eff = clamp_len(cfg_m.spike_len, 0, MAX_LEN);
        tol = cfg_m.flat_tol / 2;
        jmp = cfg_m.jump_tol;
        level = int'($urandom_range(0, 40000)) - 20000;
        k = 0;
        while (k < len) begin
            if (k != 0 && $urandom_range(0, 3) == 0) begin
                run = ($urandom_range(0, 3) != 0 && s_eff != 0) ? s_eff
                                                                : $urandom_range(1, s_eff + 1);
                up = $urandom_range(0, 1);
                while (run != 0 && k < len) begin
                    off = jmp + 1 + $urandom_range(0, 3000);
                    v = up ? level + off : level - off;
                    send_sample(to_sample(v), close && k == len - 1);
                    run--;
                    k++;
                end
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    v = int'($urandom_range(0, 65535)) - 32768;
                end else begin
                    if ($urandom_range(0, 7) == 0) level = int'($urandom_range(0, 40000)) - 20000;
                    // Now and then the jitter breaks the flat tolerance on purpose.
                    off = $urandom_range(0, ($urandom_range(0, 9) == 0) ? tol * 2 + 50 : tol);
                    v = $urandom_range(0, 1) ? level + off : level - off;
                end
                send_sample(to_sample(v), close && k == len - 1);
                k++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset settings: a lone spike in a flat signal is replaced by its left
    // neighbour.
    task automatic test_default_spike();
        t_sample_list vals;
        vals = '{16'sd0, 16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd0};
        send_list(vals);
    endtask

    // Full-scale swings: the difference of the two extremes just clears a
    // jump tolerance one below the maximum, and the right neighbour is taken.
    task automatic test_extreme_values();
        t_sample_list vals;
        set_config(make_cfg(0, 16'hFFFE, 1, 1, 1, 1'b0));
        vals = '{S_MIN, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MAX};
        send_list(vals);
    endtask

    // A spike length of zero: nothing is replaced and the delay is zero,
    // so every request releases its own sample at once.
    task automatic test_zero_spike();
        t_sample_list vals;
        set_config(make_cfg(0, 0, 1, 0, 0, 1'b1));
        vals = '{16'sd5, 16'sd999, 16'sd5};
        send_list(vals);
    endtask

    // Sequences far too short for any test position, under the longest
    // lengths: the end flag flushes them unchanged.
    task automatic test_short_sequence();
        t_sample_list vals;
        set_config(make_cfg(16'hFFFF, 0, MAX_LEN, MAX_LEN, MAX_LEN, 1'b1));
        vals = '{16'sd77};
        send_list(vals);
        vals = '{16'sd100, -16'sd100};
        send_list(vals);
    endtask

    // Registers change in the middle of a sequence while samples are held:
    // first the delay shrinks, so several held samples come out at once,
    // then it grows again before the sequence is closed.
    task automatic test_delay_change();
        idle_odds = 3;
        set_config(make_cfg(100, 500, 2, 3, 3, 1'b1));
        send_sequence(12, 1'b0);
        set_config(make_cfg(100, 500, 2, 0, 1, 1'b1));
        send_sequence(8, 1'b0);
        set_config(make_cfg(100, 500, 3, 4, 4, 1'b0));
        send_sequence(12, 1'b1);
    endtask

    // Random phases, each with its own settings and idling. The first three
    // phases pin the extremes: all lengths at zero, all lengths beyond the
    // maximum with the widest flat tolerance, and a jump tolerance so large
    // that nothing can be replaced. The last phases run without idling.
    task automatic test_random_settings();
        int unsigned target, phase, nseq, len, b, d;
        t_cfg        c;
        target = sent_count + RANDOM_ITEMS;
        phase = 0;
        while (sent_count < target || idle_odds != 0) begin
            case (phase)
                0: c = make_cfg(0, 0, 0, 0, 0, $urandom_range(0, 1));
                1: c = make_cfg(16'hFFFF, $urandom_range(500, 2000), 15, 15, 15, 1'b1);
                2: c = make_cfg($urandom_range(0, 200), 16'hFFFF, $urandom_range(1, 3),
                                $urandom_range(0, 2), $urandom_range(1, 3), 1'b0);
                default: begin
                    c = make_cfg($urandom_range(0, 300), $urandom_range(0, 3000),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(1, 3),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(0, 2),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(1, 3),
                                 $urandom_range(0, 1));
                end
            endcase
            idle_odds = (sent_count + 20 >= target) ? 0 : $urandom_range(0, 4);
            set_config(c);
            b = clamp_len(c.before_len, 1, MAX_LEN);
            d = clamp_len(c.spike_len, 0, MAX_LEN) + clamp_len(c.after_len, 0, MAX_LEN);
            nseq = $urandom_range(1, 2);
            while (nseq != 0) begin
                // Mostly long enough for tests to happen, now and then tiny.
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                  : b + d + $urandom_range(2, 10);
                send_sequence(len, 1'b1);
                nseq--;
            end
            phase++;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_FLAT_TOL;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.sample_in <= '0;
        in_ch.end_of_stream <= 1'b0;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            orig_win[k] = '0;
            filt_win[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_spike();
        test_extreme_values();
        test_zero_spike();
        test_short_sequence();
        test_delay_change();
        test_random_settings();

        wait_drained();
        $display("Run covered %0d sample requests and %0d filtered samples over %0d settings,",
                 sent_count, out_count, cfg_count);
        $display("including length clamps, zero spike length and changes mid-sequence.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(TIMEOUT_TU);
        $display("timeout with %0d samples still awaited", filtered_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
